// ===== src/bedc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded edit distance classifier package
// Shared widths, codes, the keyboard neighbor table and the control structs.
// ----------------------------------------------------------------------------
package bedc_pkg;

   localparam int MAX_LEN_DEF = 32;
   localparam int CHAR_W      = 8;
   localparam int DIST_W      = 6;
   localparam int DINT_W      = 4;
   localparam int CLASS_W     = 3;
   localparam int COST_W      = 13;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROXIMITY_ENABLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE_COST   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PROX_COST  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PROXIMITY_COST   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INSERTION_COST   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OMISSION_COST    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBST_COST       = 3'd7;

   localparam logic [CLASS_W-1:0] CLASS_NONE        = 3'd0;
   localparam logic [CLASS_W-1:0] CLASS_TRANSPOSE   = 3'd1;
   localparam logic [CLASS_W-1:0] CLASS_PROXIMITY   = 3'd2;
   localparam logic [CLASS_W-1:0] CLASS_INSERTION   = 3'd3;
   localparam logic [CLASS_W-1:0] CLASS_OMISSION    = 3'd4;
   localparam logic [CLASS_W-1:0] CLASS_SUBSTITUTE  = 3'd5;

   localparam logic [CHAR_W-1:0] UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

   typedef struct packed {
      logic accept;
      logic scan_init;
      logic scan_rd;
      logic scan_ex;
      logic decide;
      logic row_rd;
      logic cell_rd;
      logic cell_ex;
      logic row_end;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic last_item;
      logic scan_empty;
      logic scan_last;
      logic early;
      logic col_last;
      logic row_stop;
      logic rsp_free;
   } status_type;

   function automatic logic [25:0] key(input logic [CHAR_W-1:0] ch);
      key = 26'd1 << 5'(ch - LOWER_A);
   endfunction

   // Keys that sit next to each letter on a QWERTY layout.
   function automatic logic [25:0] near_mask(input logic [4:0] idx);
      unique case (idx)
         5'd0:  near_mask = key("q") | key("w") | key("s") | key("z") | key("x");
         5'd1:  near_mask = key("f") | key("g") | key("h") | key("v") | key("n");
         5'd2:  near_mask = key("s") | key("d") | key("f") | key("x") | key("v");
         5'd3:  near_mask = key("w") | key("e") | key("r") | key("s") | key("f")
                          | key("x") | key("c") | key("v");
         5'd4:  near_mask = key("w") | key("r") | key("s") | key("d") | key("f");
         5'd5:  near_mask = key("e") | key("r") | key("t") | key("d") | key("g")
                          | key("c") | key("v") | key("b");
         5'd6:  near_mask = key("r") | key("t") | key("y") | key("f") | key("h")
                          | key("v") | key("b") | key("n");
         5'd7:  near_mask = key("t") | key("y") | key("u") | key("g") | key("j")
                          | key("b") | key("n") | key("m");
         5'd8:  near_mask = key("u") | key("o") | key("j") | key("k") | key("l");
         5'd9:  near_mask = key("y") | key("u") | key("i") | key("h") | key("k")
                          | key("n") | key("m");
         5'd10: near_mask = key("u") | key("i") | key("o") | key("j") | key("l")
                          | key("m");
         5'd11: near_mask = key("i") | key("o") | key("p") | key("k");
         5'd12: near_mask = key("h") | key("j") | key("k") | key("n");
         5'd13: near_mask = key("g") | key("h") | key("j") | key("b") | key("m");
         5'd14: near_mask = key("i") | key("p") | key("k") | key("l");
         5'd15: near_mask = key("o") | key("l");
         5'd16: near_mask = key("w") | key("a") | key("s");
         5'd17: near_mask = key("e") | key("t") | key("d") | key("f") | key("g");
         5'd18: near_mask = key("q") | key("w") | key("e") | key("a") | key("d")
                          | key("z") | key("x") | key("c");
         5'd19: near_mask = key("r") | key("y") | key("f") | key("g") | key("h");
         5'd20: near_mask = key("y") | key("i") | key("h") | key("j") | key("k");
         5'd21: near_mask = key("d") | key("f") | key("g") | key("c") | key("b");
         5'd22: near_mask = key("q") | key("e") | key("a") | key("s") | key("d");
         5'd23: near_mask = key("a") | key("s") | key("d") | key("z") | key("c");
         5'd24: near_mask = key("t") | key("u") | key("g") | key("h") | key("j");
         5'd25: near_mask = key("a") | key("s") | key("x");
         default: near_mask = '0;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] ch);
      fold = (ch >= UPPER_A && ch <= UPPER_Z) ? ch + CASE_OFFSET : ch;
   endfunction

   function automatic logic keys_near(input logic [CHAR_W-1:0] a,
                                      input logic [CHAR_W-1:0] b);
      logic [CHAR_W-1:0] fa;
      logic [CHAR_W-1:0] fb;
      logic [25:0]       mask;
      fa = fold(a);
      fb = fold(b);
      mask = near_mask(5'(fa - LOWER_A));
      if (fa < LOWER_A || fa > LOWER_Z || fb < LOWER_A || fb > LOWER_Z) begin
         keys_near = 1'b0;
      end else begin
         keys_near = mask[5'(fb - LOWER_A)];
      end
   endfunction

endpackage
`default_nettype wire

// ===== src/bedc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded edit distance classifier controller
// Sequences loading, the compare scan, the DP rows and the result hand-off.
// ----------------------------------------------------------------------------
module bedc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire bedc_pkg::status_type status,
   output bedc_pkg::cmd_type         cmd
);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b0000000001,
      ST_SCAN_INIT = 10'b0000000010,
      ST_SCAN_RD   = 10'b0000000100,
      ST_SCAN_EX   = 10'b0000001000,
      ST_DECIDE    = 10'b0000010000,
      ST_ROW_RD    = 10'b0000100000,
      ST_CELL_RD   = 10'b0001000000,
      ST_CELL_EX   = 10'b0010000000,
      ST_ROW_END   = 10'b0100000000,
      ST_FINISH    = 10'b1000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      cmd           = '0;
      cmd.accept    = (state_ff == ST_IDLE) && req_valid;
      cmd.scan_init = (state_ff == ST_SCAN_INIT);
      cmd.scan_rd   = (state_ff == ST_SCAN_RD);
      cmd.scan_ex   = (state_ff == ST_SCAN_EX);
      cmd.decide    = (state_ff == ST_DECIDE);
      cmd.row_rd    = (state_ff == ST_ROW_RD);
      cmd.cell_rd   = (state_ff == ST_CELL_RD);
      cmd.cell_ex   = (state_ff == ST_CELL_EX);
      cmd.row_end   = (state_ff == ST_ROW_END);
      cmd.finish    = (state_ff == ST_FINISH) && status.rsp_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.last_item) state_in = ST_SCAN_INIT;
         end
         ST_SCAN_INIT: begin
            state_in = status.scan_empty ? ST_DECIDE : ST_SCAN_RD;
         end
         ST_SCAN_RD: state_in = ST_SCAN_EX;
         ST_SCAN_EX: begin
            state_in = status.scan_last ? ST_DECIDE : ST_SCAN_RD;
         end
         ST_DECIDE: begin
            state_in = status.early ? ST_FINISH : ST_ROW_RD;
         end
         ST_ROW_RD:  state_in = ST_CELL_RD;
         ST_CELL_RD: state_in = ST_CELL_EX;
         ST_CELL_EX: begin
            state_in = status.col_last ? ST_ROW_END : ST_CELL_RD;
         end
         ST_ROW_END: begin
            state_in = status.row_stop ? ST_FINISH : ST_ROW_RD;
         end
         ST_FINISH: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/bedc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded edit distance classifier datapath
// Word stores, configuration, compare scan, shared DP cell and result register.
// ----------------------------------------------------------------------------
module bedc_datapath #(
   parameter int MAX_LEN = bedc_pkg::MAX_LEN_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire bedc_pkg::cmd_type                    cmd,
   output bedc_pkg::status_type                      status,
   input  wire logic                                 req_word_select,
   input  wire logic [bedc_pkg::CHAR_W-1:0]          req_char_code,
   input  wire logic                                 req_char_valid,
   input  wire logic                                 req_word_end,
   input  wire logic                                 csr_wr_en,
   input  wire logic [bedc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [bedc_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_valid,
   output logic [bedc_pkg::DIST_W-1:0]               rsp_edit_distance,
   output logic [bedc_pkg::CLASS_W-1:0]              rsp_error_class,
   output logic [bedc_pkg::COST_W-1:0]               rsp_weighted_cost,
   output logic                                      rsp_length_overflow
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int DW = (LW > bedc_pkg::DINT_W) ? LW : bedc_pkg::DINT_W;
   localparam int CW = bedc_pkg::CHAR_W;

   // Configuration registers.
   logic [2:0]    max_dist_ff;
   logic          prox_en_ff;
   logic [7:0]    trans_cost_ff;
   logic [7:0]    first_prox_cost_ff;
   logic [7:0]    prox_cost_ff;
   logic [7:0]    ins_cost_ff;
   logic [7:0]    omit_cost_ff;
   logic [7:0]    subst_cost_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff        <= 3'd3;
         prox_en_ff         <= 1'b1;
         trans_cost_ff      <= '0;
         first_prox_cost_ff <= '0;
         prox_cost_ff       <= '0;
         ins_cost_ff        <= '0;
         omit_cost_ff       <= '0;
         subst_cost_ff      <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bedc_pkg::CSR_MAX_DISTANCE:     max_dist_ff        <= csr_data[2:0];
            bedc_pkg::CSR_PROXIMITY_ENABLE: prox_en_ff         <= csr_data[0];
            bedc_pkg::CSR_TRANSPOSE_COST:   trans_cost_ff      <= csr_data;
            bedc_pkg::CSR_FIRST_PROX_COST:  first_prox_cost_ff <= csr_data;
            bedc_pkg::CSR_PROXIMITY_COST:   prox_cost_ff       <= csr_data;
            bedc_pkg::CSR_INSERTION_COST:   ins_cost_ff        <= csr_data;
            bedc_pkg::CSR_OMISSION_COST:    omit_cost_ff       <= csr_data;
            bedc_pkg::CSR_SUBST_COST:       subst_cost_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // Word loading.
   logic [CW-1:0] typed_mem [0:MAX_LEN-1];
   logic [CW-1:0] cand_mem  [0:MAX_LEN-1];
   logic [LW-1:0] typed_len_ff;
   logic [LW-1:0] cand_len_ff;
   logic          typed_ovf_ff;
   logic          cand_ovf_ff;
   logic          typed_new_ff;
   logic          cand_new_ff;
   logic [LW-1:0] typed_base;
   logic [LW-1:0] cand_base;
   logic          typed_room;
   logic          cand_room;
   logic          typed_wr;
   logic          cand_wr;

   always_comb begin
      typed_base = typed_new_ff ? '0 : typed_len_ff;
      cand_base  = cand_new_ff ? '0 : cand_len_ff;
      typed_room = typed_base < LW'(MAX_LEN);
      cand_room  = cand_base < LW'(MAX_LEN);
      typed_wr   = cmd.accept && !req_word_select && req_char_valid && typed_room;
      cand_wr    = cmd.accept && req_word_select && req_char_valid && cand_room;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         typed_len_ff <= '0;
         cand_len_ff  <= '0;
         typed_ovf_ff <= 1'b0;
         cand_ovf_ff  <= 1'b0;
         typed_new_ff <= 1'b1;
         cand_new_ff  <= 1'b1;
      end else if (cmd.accept) begin
         if (!req_word_select) begin
            typed_len_ff <= typed_base + LW'(typed_wr);
            typed_ovf_ff <= (typed_ovf_ff && !typed_new_ff)
                            || (req_char_valid && !typed_room);
            typed_new_ff <= req_word_end;
         end else begin
            cand_len_ff <= cand_base + LW'(cand_wr);
            cand_ovf_ff <= (cand_ovf_ff && !cand_new_ff)
                           || (req_char_valid && !cand_room);
            cand_new_ff <= req_word_end;
         end
      end
   end

   // Scan and DP counters.
   logic [LW-1:0] k_ff;
   logic [LW-1:0] i_ff;
   logic [LW-1:0] j_ff;
   logic [LW-1:0] im1;
   logic [LW-1:0] jm1;
   logic          pbank_ff;
   logic          first_row_ff;

   assign im1 = i_ff - LW'(1);
   assign jm1 = j_ff - LW'(1);

   logic [CW-1:0] typed_rd_ff;
   logic [CW-1:0] cand_rd_ff;
   logic [DW-1:0] dp_rd_ff;
   logic [DW-1:0] dp_mem [0:(2**(AW+1))-1];
   logic [DW-1:0] cell_v;

   always_ff @(posedge clock) begin
      if (typed_wr) typed_mem[typed_base[AW-1:0]] <= req_char_code;
      if (cmd.scan_rd) begin
         typed_rd_ff <= typed_mem[k_ff[AW-1:0]];
      end else if (cmd.row_rd) begin
         typed_rd_ff <= typed_mem[im1[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cand_wr) cand_mem[cand_base[AW-1:0]] <= req_char_code;
      if (cmd.scan_rd) begin
         cand_rd_ff <= cand_mem[k_ff[AW-1:0]];
      end else if (cmd.cell_rd) begin
         cand_rd_ff <= cand_mem[jm1[AW-1:0]];
      end
   end

   // Two row banks; the row being built goes to the bank not being read.
   always_ff @(posedge clock) begin
      if (cmd.cell_ex) dp_mem[{~pbank_ff, jm1[AW-1:0]}] <= cell_v;
      if (cmd.cell_rd) dp_rd_ff <= dp_mem[{pbank_ff, jm1[AW-1:0]}];
   end

   // Compare scan.
   logic          neq_ff;
   logic          trans_ff;
   logic          prox_ff;
   logic          prox_first_ff;
   logic [CW-1:0] tprev_ff;
   logic [CW-1:0] cprev_ff;
   logic [LW-1:0] min_len;
   logic          chars_ne;

   assign min_len  = (typed_len_ff < cand_len_ff) ? typed_len_ff : cand_len_ff;
   assign chars_ne = typed_rd_ff != cand_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         k_ff     <= '0;
         neq_ff   <= 1'b0;
         trans_ff <= 1'b0;
         prox_ff  <= 1'b0;
      end else if (cmd.scan_ex) begin
         k_ff     <= k_ff + LW'(1);
         tprev_ff <= typed_rd_ff;
         cprev_ff <= cand_rd_ff;
         if (chars_ne) neq_ff <= 1'b1;
         if (k_ff != '0 && tprev_ff == cand_rd_ff && typed_rd_ff == cprev_ff) begin
            trans_ff <= 1'b1;
         end
         if (!prox_ff && chars_ne && bedc_pkg::keys_near(typed_rd_ff, cand_rd_ff)) begin
            prox_ff       <= 1'b1;
            prox_first_ff <= (k_ff == '0);
         end
      end
   end

   // Early decisions before the DP.
   logic [DW-1:0] md_w;
   logic [DW-1:0] md1_w;
   logic [DW-1:0] la_w;
   logic [DW-1:0] lb_w;
   logic [DW-1:0] diff_w;
   logic          words_equal;
   logic          early;
   logic [DW-1:0] early_dist;

   always_comb begin
      md_w        = DW'(max_dist_ff);
      md1_w       = md_w + DW'(1);
      la_w        = DW'(typed_len_ff);
      lb_w        = DW'(cand_len_ff);
      diff_w      = (la_w > lb_w) ? la_w - lb_w : lb_w - la_w;
      words_equal = (typed_len_ff == cand_len_ff) && !neq_ff;
      early       = words_equal || (diff_w > md_w) || (la_w == '0) || (lb_w == '0);
      if (words_equal) begin
         early_dist = '0;
      end else if (diff_w > md_w) begin
         early_dist = md1_w;
      end else if (la_w == '0) begin
         early_dist = (lb_w < md1_w) ? lb_w : md1_w;
      end else begin
         early_dist = (la_w < md1_w) ? la_w : md1_w;
      end
   end

   // Shared DP cell.
   logic [DW-1:0] diag_ff;
   logic [DW-1:0] left_ff;
   logic [DW-1:0] mn_ff;
   logic [DW-1:0] last_v_ff;
   logic [DW-1:0] up_v;
   logic [DW-1:0] min_dl;
   logic [DW-1:0] min3;
   logic [bedc_pkg::DINT_W-1:0] dist_ff;

   always_comb begin
      up_v   = first_row_ff ? DW'(j_ff) : dp_rd_ff;
      min_dl = (diag_ff < left_ff) ? diag_ff : left_ff;
      min3   = (up_v < min_dl) ? up_v : min_dl;
      cell_v = (typed_rd_ff == cand_rd_ff) ? diag_ff : min3 + DW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         i_ff         <= LW'(1);
         pbank_ff     <= 1'b0;
         first_row_ff <= 1'b1;
         if (early) dist_ff <= bedc_pkg::DINT_W'(early_dist);
      end else if (cmd.row_rd) begin
         j_ff    <= LW'(1);
         diag_ff <= DW'(im1);
         left_ff <= DW'(i_ff);
         mn_ff   <= DW'(i_ff);
      end else if (cmd.cell_ex) begin
         j_ff      <= j_ff + LW'(1);
         diag_ff   <= up_v;
         left_ff   <= cell_v;
         last_v_ff <= cell_v;
         if (cell_v < mn_ff) mn_ff <= cell_v;
      end else if (cmd.row_end) begin
         if (mn_ff > md_w) begin
            dist_ff <= bedc_pkg::DINT_W'(md1_w);
         end else if (i_ff == typed_len_ff) begin
            dist_ff <= bedc_pkg::DINT_W'((last_v_ff > md1_w) ? md1_w : last_v_ff);
         end else begin
            i_ff         <= i_ff + LW'(1);
            pbank_ff     <= ~pbank_ff;
            first_row_ff <= 1'b0;
         end
      end
   end

   // Classification.
   logic [bedc_pkg::CLASS_W-1:0] cls;
   logic [7:0]                   base_cost;
   logic                         scale;
   logic [bedc_pkg::COST_W-1:0]  cost;

   always_comb begin
      cls       = bedc_pkg::CLASS_NONE;
      base_cost = '0;
      scale     = 1'b0;
      if (dist_ff != '0) begin
         priority if (typed_len_ff == cand_len_ff && dist_ff == 4'd2 && trans_ff) begin
            cls       = bedc_pkg::CLASS_TRANSPOSE;
            base_cost = trans_cost_ff;
         end else if (dist_ff == 4'd1 && prox_en_ff && prox_ff) begin
            cls       = bedc_pkg::CLASS_PROXIMITY;
            base_cost = prox_first_ff ? first_prox_cost_ff : prox_cost_ff;
         end else if (typed_len_ff > cand_len_ff) begin
            cls       = bedc_pkg::CLASS_INSERTION;
            base_cost = ins_cost_ff;
            scale     = 1'b1;
         end else if (typed_len_ff < cand_len_ff) begin
            cls       = bedc_pkg::CLASS_OMISSION;
            base_cost = omit_cost_ff;
            scale     = 1'b1;
         end else begin
            cls       = bedc_pkg::CLASS_SUBSTITUTE;
            base_cost = subst_cost_ff;
            scale     = 1'b1;
         end
      end
      cost = scale ? bedc_pkg::COST_W'(base_cost) * bedc_pkg::COST_W'(dist_ff)
                   : bedc_pkg::COST_W'(base_cost);
   end

   // Result register.
   logic rsp_valid_ff;
   logic [bedc_pkg::DIST_W-1:0]  rsp_dist_ff;
   logic [bedc_pkg::CLASS_W-1:0] rsp_class_ff;
   logic [bedc_pkg::COST_W-1:0]  rsp_cost_ff;
   logic                         rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_dist_ff  <= bedc_pkg::DIST_W'(dist_ff);
         rsp_class_ff <= cls;
         rsp_cost_ff  <= cost;
         rsp_ovf_ff   <= typed_ovf_ff || cand_ovf_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_edit_distance   = rsp_dist_ff;
   assign rsp_error_class     = rsp_class_ff;
   assign rsp_weighted_cost   = rsp_cost_ff;
   assign rsp_length_overflow = rsp_ovf_ff;

   always_comb begin
      status            = '0;
      status.last_item  = req_word_select && req_word_end;
      status.scan_empty = (min_len == '0);
      status.scan_last  = (k_ff == min_len - LW'(1));
      status.early      = early;
      status.col_last   = (j_ff == cand_len_ff);
      status.row_stop   = (mn_ff > md_w) || (i_ff == typed_len_ff);
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule
`default_nettype wire

// ===== src/bounded_edit_distance_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded edit distance classifier
// Loads a typed word and a candidate word a byte per request and answers with
// the bounded Levenshtein distance, an error class and a Q5.8 cost.
//
// Requests carry one byte of either word (req_word_select). A typed word stays
// stored until a new typed word starts. Only the request that ends a candidate
// word produces a response on the rsp_ channel. Each byte request is taken
// while req_stall is low; after the request that ends a candidate, req_stall
// stays high while the block computes. The block walks both words once,
// reading and comparing each position of the shorter word, then runs the DP
// with a single shared cell reading one row bank and writing the other, one
// row per typed character. The DP stops early once a row minimum passes the
// bound, and runs no rows when equal words, an empty word or a length gap
// decide it. The next request can be taken at the edge after rsp_valid
// rises. The response sits in an output register; while rsp_stall is high
// it holds, and the block waits before writing the next one. Configuration
// is written through csr_wr_en/csr_index/csr_data; the user must do so only
// while idle, as the block itself does not enforce it. Reset (synchronous)
// clears lengths, flags and configuration registers to their defaults;
// stored bytes are not cleared.
// ----------------------------------------------------------------------------
module bounded_edit_distance_classifier #(
   parameter int MAX_LEN = bedc_pkg::MAX_LEN_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_word_select,
   input  wire logic [bedc_pkg::CHAR_W-1:0]          req_char_code,
   input  wire logic                                 req_char_valid,
   input  wire logic                                 req_word_end,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [bedc_pkg::DIST_W-1:0]               rsp_edit_distance,
   output logic [bedc_pkg::CLASS_W-1:0]              rsp_error_class,
   output logic [bedc_pkg::COST_W-1:0]               rsp_weighted_cost,
   output logic                                      rsp_length_overflow,
   input  wire logic                                 csr_wr_en,
   input  wire logic [bedc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [bedc_pkg::CSR_DATA_W-1:0]      csr_data
);

   bedc_pkg::cmd_type    cmd;
   bedc_pkg::status_type status;

   bedc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bedc_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_word_select     (req_word_select),
      .req_char_code       (req_char_code),
      .req_char_valid      (req_char_valid),
      .req_word_end        (req_word_end),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_edit_distance   (rsp_edit_distance),
      .rsp_error_class     (rsp_error_class),
      .rsp_weighted_cost   (rsp_weighted_cost),
      .rsp_length_overflow (rsp_length_overflow)
   );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded edit distance classifier testbench
// Streams typed and candidate words into the block under random sender gaps
// and receiver stalls, predicts each distance, class, cost and overflow flag
// with a behavioral model of the scoring rules, and checks every response.
// ----------------------------------------------------------------------------
module tb_top;
   import bedc_pkg::*;

   localparam int WORD_MAX = 32;

   typedef struct packed {
      logic [DIST_W-1:0]  distance;
      logic [CLASS_W-1:0] cls;
      logic [COST_W-1:0]  cost;
      logic               ovf;
   } score_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_word_select = 1'b0;
   logic [CHAR_W-1:0] req_char_code = '0;
   logic req_char_valid = 1'b0;
   logic req_word_end = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [DIST_W-1:0] rsp_edit_distance;
   logic [CLASS_W-1:0] rsp_error_class;
   logic [COST_W-1:0] rsp_weighted_cost;
   logic rsp_length_overflow;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   bounded_edit_distance_classifier dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow state of the block.
   byte unsigned typed_buf[WORD_MAX];
   byte unsigned cand_buf[WORD_MAX];
   int typed_len = 0, cand_len = 0;
   bit typed_ovf = 0, cand_ovf = 0, typed_fresh = 1, cand_fresh = 1;
   int bound_reg = 3;
   bit prox_en_reg = 1;
   int cost_reg[8] = '{default: 0};

   score_t expected_scores[$];
   int errors = 0, requests_sent = 0, scores_checked = 0, burst_left = 0;
   int hold_left = 0;

   string near_tab[26] = '{"qwszx", "fghvn", "sdfxv", "wersfxcv", "wrsdf", "ertdgcvb",
      "rtyfhvbn", "tyugjbnm", "uojkl", "yuihknm", "uiojlm", "iopk", "hjkn", "ghjbm",
      "ipkl", "ol", "was", "etdfg", "qweadzxc", "ryfgh", "yihjk", "dfgcb", "qeasd",
      "asdzc", "tughj", "asx"};

   function automatic int to_lower(int c);
      return (c >= 65 && c <= 90) ? c + 32 : c;
   endfunction

   function automatic bit adjacent_keys(int a, int b);
      int fa, fb;
      string row;
      fa = to_lower(a);
      fb = to_lower(b);
      if (fa < 97 || fa > 122 || fb < 97 || fb > 122) return 0;
      row = near_tab[fa-97];
      for (int k = 0; k < row.len(); k++)
         if (row[k] == fb) return 1;
      return 0;
   endfunction

   function automatic int bounded_levenshtein();
      int la, lb, diff, lim, mn, v;
      int prev[WORD_MAX+1];
      int cur[WORD_MAX+1];
      bit same;
      la = typed_len;
      lb = cand_len;
      lim = bound_reg + 1;
      diff = la > lb ? la - lb : lb - la;
      same = (la == lb);
      for (int i = 0; i < la && same; i++)
         if (typed_buf[i] != cand_buf[i]) same = 0;
      if (same) return 0;
      if (diff > bound_reg) return lim;
      if (la == 0) return lb < lim ? lb : lim;
      if (lb == 0) return la < lim ? la : lim;
      for (int j = 0; j <= lb; j++) prev[j] = j;
      for (int i = 1; i <= la; i++) begin
         mn = i;
         cur[0] = i;
         for (int j = 1; j <= lb; j++) begin
            v = prev[j-1];
            if (typed_buf[i-1] != cand_buf[j-1]) begin
               if (prev[j] < v) v = prev[j];
               if (cur[j-1] < v) v = cur[j-1];
               v++;
            end
            cur[j] = v;
            if (v < mn) mn = v;
         end
         if (mn > bound_reg) return lim;
         prev = cur;
      end
      return prev[lb] > lim ? lim : prev[lb];
   endfunction

   function automatic score_t score_pair();
      score_t s;
      int d, minlen, cls, cost;
      d = bounded_levenshtein();
      minlen = typed_len < cand_len ? typed_len : cand_len;
      cls = CLASS_NONE;
      cost = 0;
      if (d != 0) begin
         if (typed_len == cand_len && d == 2)
            for (int i = 0; i + 1 < minlen && cls == CLASS_NONE; i++)
               if (typed_buf[i] == cand_buf[i+1] && typed_buf[i+1] == cand_buf[i]) begin
                  cls = CLASS_TRANSPOSE;
                  cost = cost_reg[CSR_TRANSPOSE_COST];
               end
         if (cls == CLASS_NONE && d == 1 && prox_en_reg)
            for (int i = 0; i < minlen && cls == CLASS_NONE; i++)
               if (typed_buf[i] != cand_buf[i] && adjacent_keys(typed_buf[i], cand_buf[i]))
               begin
                  cls = CLASS_PROXIMITY;
                  cost = (i == 0) ? cost_reg[CSR_FIRST_PROX_COST]
                                  : cost_reg[CSR_PROXIMITY_COST];
               end
         if (cls == CLASS_NONE) begin
            if (typed_len > cand_len) begin
               cls = CLASS_INSERTION;
               cost = cost_reg[CSR_INSERTION_COST] * d;
            end else if (typed_len < cand_len) begin
               cls = CLASS_OMISSION;
               cost = cost_reg[CSR_OMISSION_COST] * d;
            end else begin
               cls = CLASS_SUBSTITUTE;
               cost = cost_reg[CSR_SUBST_COST] * d;
            end
         end
      end
      s.distance = DIST_W'(d);
      s.cls = CLASS_W'(cls);
      s.cost = COST_W'(cost);
      s.ovf = typed_ovf | cand_ovf;
      return s;
   endfunction

   // Applies one accepted request to the shadow state.
   function automatic void absorb_request(bit sel, byte unsigned ch, bit cv, bit we);
      if (!sel) begin
         if (typed_fresh) begin
            typed_len = 0;
            typed_ovf = 0;
            typed_fresh = 0;
         end
         if (cv) begin
            if (typed_len < WORD_MAX) typed_buf[typed_len++] = ch;
            else typed_ovf = 1;
         end
         if (we) typed_fresh = 1;
      end else begin
         if (cand_fresh) begin
            cand_len = 0;
            cand_ovf = 0;
            cand_fresh = 0;
         end
         if (cv) begin
            if (cand_len < WORD_MAX) cand_buf[cand_len++] = ch;
            else cand_ovf = 1;
         end
         if (we) begin
            cand_fresh = 1;
            expected_scores.push_back(score_pair());
         end
      end
   endfunction

   task automatic send_request(bit sel, byte unsigned ch, bit cv, bit we);
      req_valid <= 1'b1;
      req_word_select <= sel;
      req_char_code <= ch;
      req_char_valid <= cv;
      req_word_end <= we;
      do @(posedge clock); while (req_stall);
      absorb_request(sel, ch, cv, we);
      requests_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(0, 15);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // An empty word travels as one request without a byte.
   task automatic send_word(bit sel, byte unsigned w[$]);
      if (w.size() == 0) begin
         send_request(sel, byte'($urandom_range(0, 255)), 1'b0, 1'b1);
      end else begin
         foreach (w[i]) begin
            if ($urandom_range(0, 19) == 0)
               send_request(sel, byte'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_request(sel, w[i], 1'b1, i == w.size() - 1);
         end
      end
   endtask

   task automatic send_pair(string t, string c);
      byte unsigned tw[$], cw[$];
      for (int i = 0; i < t.len(); i++) tw.push_back(t[i]);
      for (int i = 0; i < c.len(); i++) cw.push_back(c[i]);
      if (t != "=") send_word(1'b0, tw);
      send_word(1'b1, cw);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_MAX_DISTANCE: bound_reg = value & 7;
         CSR_PROXIMITY_ENABLE: prox_en_reg = value[0];
         default: cost_reg[idx] = value & 8'hFF;
      endcase
   endtask

   task automatic load_costs(int md, int pe, int c2, int c3, int c4, int c5, int c6, int c7);
      wait_idle();
      write_csr(CSR_MAX_DISTANCE, md);
      write_csr(CSR_PROXIMITY_ENABLE, pe);
      write_csr(CSR_TRANSPOSE_COST, c2);
      write_csr(CSR_FIRST_PROX_COST, c3);
      write_csr(CSR_PROXIMITY_COST, c4);
      write_csr(CSR_INSERTION_COST, c5);
      write_csr(CSR_OMISSION_COST, c6);
      write_csr(CSR_SUBST_COST, c7);
   endtask

   task automatic test_defaults();
      send_pair("cat", "cat");
      send_pair("", "abc");
      send_pair("abcd", "");
      send_pair("", "");
   endtask

   task automatic test_classes();
      load_costs(3, 1, 17, 200, 33, 41, 59, 71);
      send_pair("abcd", "bacd");
      send_pair("cat", "vat");
      send_pair("Cat", "cst");
      send_pair("1at", "2at");
      send_pair("=", "cap");
      send_pair("house", "hose");
      send_pair("hose", "horse");
      send_pair("\x7f\xff", "\x80\x00");
   endtask

   task automatic test_extremes();
      string long33;
      long33 = "abcdefghijklmnopqrstuvwxyzABCDEFG";
      load_costs(7, 0, 255, 255, 255, 255, 255, 255);
      send_pair("cat", "vat");
      send_pair(long33, long33);
      send_pair("=", "abcdefg");
      send_pair("abcdefghijkl", "lkjihgfedcba");
      load_costs(0, 1, 0, 0, 0, 0, 0, 0);
      send_pair("ab", "ba");
      send_pair("ab", "ab");
      send_pair("", "q");
   endtask

   function automatic byte unsigned random_byte();
      string pool;
      pool = "asdwqeASDzx";
      case ($urandom_range(0, 5))
         0: return byte'($urandom_range(0, 255));
         1: return byte'($urandom_range(97, 122));
         default: return pool[$urandom_range(0, pool.len() - 1)];
      endcase
   endfunction

   task automatic test_random(int target);
      byte unsigned tw[$], cw[$];
      int n, pos, tmp, last_cfg;
      last_cfg = 0;
      while (requests_sent < target) begin
         if (requests_sent - last_cfg > 100) begin
            last_cfg = requests_sent;
            load_costs($urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255));
         end
         // Mostly short words; a few run past the store to hit the overflow flag.
         n = ($urandom_range(0, 24) == 0) ? $urandom_range(30, 35) : $urandom_range(0, 7);
         if ($urandom_range(0, 3) != 0 || typed_len == 0) begin
            tw.delete();
            repeat (n) tw.push_back(random_byte());
            send_word(1'b0, tw);
         end
         cw = tw;
         case ($urandom_range(0, 6))
            0: if (cw.size() > 1) begin
                  pos = $urandom_range(0, cw.size() - 2);
                  tmp = cw[pos];
                  cw[pos] = cw[pos+1];
                  cw[pos+1] = tmp;
               end
            1: if (cw.size() > 0) cw[$urandom_range(0, cw.size() - 1)] = random_byte();
            2: cw.insert($urandom_range(0, cw.size()), random_byte());
            3: if (cw.size() > 0) cw.delete($urandom_range(0, cw.size() - 1));
            4: begin
                  cw.delete();
                  repeat ($urandom_range(0, 8)) cw.push_back(random_byte());
               end
            default: ;
         endcase
         send_word(1'b1, cw);
      end
   endtask

   // Response checker and receiver stall pattern.
   always @(posedge clock) begin
      score_t want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_left == 0) begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            hold_left <= $urandom_range(0, 12);
         end else begin
            hold_left <= hold_left - 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_scores.size() == 0) begin
               $error("unexpected response: distance %0d", rsp_edit_distance);
               errors++;
            end else begin
               want = expected_scores.pop_front();
               scores_checked++;
               if (rsp_edit_distance !== want.distance) begin
                  $error("edit_distance: expected %0d, got %0d", want.distance,
                         rsp_edit_distance);
                  errors++;
               end
               if (rsp_error_class !== want.cls) begin
                  $error("error_class: expected %0d, got %0d", want.cls, rsp_error_class);
                  errors++;
               end
               if (rsp_weighted_cost !== want.cost) begin
                  $error("weighted_cost: expected %0d, got %0d", want.cost, rsp_weighted_cost);
                  errors++;
               end
               if (rsp_length_overflow !== want.ovf) begin
                  $error("length_overflow: expected %0d, got %0d", want.ovf,
                         rsp_length_overflow);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_classes();
      test_extremes();
      test_random(600);
      wait_idle();
      repeat (40) @(posedge clock);
      if (expected_scores.size() != 0) begin
         $error("%0d responses never arrived", expected_scores.size());
         errors++;
      end
      $display("Sent %0d requests and checked %0d scores across several bound and cost",
               requests_sent, scores_checked);
      $display("settings, with transpositions, near keys, empty and overlong words.");
      if (errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
src/bedc_pkg.sv
src/bedc_ctrl.sv
src/bedc_datapath.sv
src/bounded_edit_distance_classifier.sv
tb/tb_top.sv
